// ===== rtl/ptt_pkg.sv =====
// Shared constants and types for the periodic task timer bank.
`default_nettype none

package ptt_pkg;

    localparam int NUM_ENTRIES_DEF = 16;   // default number of timer entries
    localparam int TIME_W          = 16;   // period / remaining time width (ms)
    localparam int TICK_W          = 10;   // tick period register width
    localparam int IDX_OUT_W       = 4;    // entry index width on the ports
    localparam int ADDR_W          = 2;    // APB byte address width
    localparam int DATA_W          = 32;   // APB data width

    localparam logic [ADDR_W-1:0] REG_TICK_PERIOD = 2'd0;
    localparam logic [TICK_W-1:0] TICK_RESET      = 10'd1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // One timer entry as kept in the entry memory.
    typedef struct packed {
        logic              enable;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] remain;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/periodic_task_timer_bank.sv =====
// Periodic task timer bank: entry memory, tick walker and result register.
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    s_cmd, s_entry_index, s_entry_period,
//                                   s_entry_delay, s_entry_enable
// m_        out  m_valid/m_ready    m_fired_index, m_last_fire
// APB       in   psel/penable/...   tick_period_ms at byte address 0
//
// A load item is written into the entry memory in the cycle it is accepted.
// A tick item walks the entry memory one entry per cycle, except while
// stalled, through one shared evaluate/decrement unit, then flushes, waiting
// for a free result register; s_ready is low throughout. The read port
// of the entry memory is pipelined one entry ahead of the write-back.
// Reset (synchronous, aresetn low) clears the per-entry valid bits at once;
// an entry never written reads as all zero, so no clearing pass is needed.
// s_ready is high only while no tick is in progress. A fire is held until the
// next fire or the flush so that the last fire of a tick can be marked; the
// walk stalls only when a second fire finds the result register occupied.

module periodic_task_timer_bank #(
    parameter int NUM_ENTRIES = ptt_pkg::NUM_ENTRIES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input items
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_cmd,
    input  wire logic [ptt_pkg::IDX_OUT_W-1:0] s_entry_index,
    input  wire logic [ptt_pkg::TIME_W-1:0]    s_entry_period,
    input  wire logic [ptt_pkg::TIME_W-1:0]    s_entry_delay,
    input  wire logic                          s_entry_enable,
    // fire results
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [ptt_pkg::IDX_OUT_W-1:0]      m_fired_index,
    output logic                               m_last_fire,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ptt_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [ptt_pkg::DATA_W-1:0]    pwdata,
    output logic [ptt_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
    localparam int IDXC_W = (IDX_W > ptt_pkg::IDX_OUT_W) ? IDX_W + 1 : ptt_pkg::IDX_OUT_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    // ---------------- configuration ----------------
    logic [ptt_pkg::TICK_W-1:0] tick_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= ptt_pkg::TICK_RESET;
        end else if (cfg_wr && (paddr == ptt_pkg::REG_TICK_PERIOD)) begin
            tick_reg <= pwdata[ptt_pkg::TICK_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ptt_pkg::REG_TICK_PERIOD) begin
            prdata = ptt_pkg::DATA_W'(tick_reg);
        end
    end

    // ---------------- control registers ----------------
    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;        // next entry to read
    logic                       ev_vld_reg, ev_vld_next;  // read data is live
    logic [IDX_W-1:0]           ev_idx_reg, ev_idx_next;
    logic                       held_vld_reg, held_vld_next;
    logic [IDX_W-1:0]           held_idx_reg, held_idx_next;
    logic                       out_vld_reg, out_vld_next;
    logic [ptt_pkg::IDX_OUT_W-1:0] out_idx_reg, out_idx_next;
    logic                       out_last_reg, out_last_next;

    // ---------------- entry memory ----------------
    ptt_pkg::entry_t            mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0]     ent_vld_reg;
    ptt_pkg::entry_t            rd_data_reg;
    logic                       rd_valid_reg;
    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    ptt_pkg::entry_t            wr_data;

    // ---------------- shared evaluate unit ----------------
    ptt_pkg::entry_t            ev_entry;
    logic                       fire;
    logic [ptt_pkg::TIME_W-1:0] reload;
    logic [ptt_pkg::TIME_W-1:0] tick_ext;
    logic [ptt_pkg::TIME_W-1:0] dec;
    logic                       out_free;
    logic                       stall;
    logic                       issue;
    logic                       s_acc;
    logic                       load_ok;
    logic [IDX_W-1:0]           load_addr;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign load_ok = s_acc && (s_cmd == ptt_pkg::CMD_LOAD) &&
                     (IDXC_W'(s_entry_index) < IDXC_W'(NUM_ENTRIES));
    assign load_addr = IDX_W'(s_entry_index);

    // Entries never written read as zero: disabled, period and time zero.
    assign ev_entry = rd_valid_reg ? rd_data_reg : '0;
    assign fire     = ev_vld_reg && ev_entry.enable && (ev_entry.remain == '0);
    assign reload   = fire ? ev_entry.period : ev_entry.remain;
    assign tick_ext = ptt_pkg::TIME_W'(tick_reg);
    assign dec      = (reload > tick_ext) ? (reload - tick_ext) : '0;

    assign out_free = !out_vld_reg || m_ready;
    // A second fire needs the result register for the held one.
    assign stall    = fire && held_vld_reg && !out_free;
    assign issue    = (state_reg == ST_WALK) && (cnt_reg != CNT_W'(NUM_ENTRIES)) && !stall;

    assign rd_en   = issue;
    assign rd_addr = cnt_reg[IDX_W-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = load_addr;
        wr_data = '{enable: s_entry_enable, period: s_entry_period, remain: s_entry_delay};
        if (load_ok) begin
            wr_en = 1'b1;
        end else if ((state_reg == ST_WALK) && ev_vld_reg && !stall) begin
            wr_en   = 1'b1;
            wr_addr = ev_idx_reg;
            wr_data = '{enable: ev_entry.enable, period: ev_entry.period, remain: dec};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_vld_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                ent_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= ent_vld_reg[rd_addr];
            end
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ev_vld_next   = ev_vld_reg;
        ev_idx_next   = ev_idx_reg;
        held_vld_next = held_vld_reg;
        held_idx_next = held_idx_reg;
        out_vld_next  = out_vld_reg && !m_ready;
        out_idx_next  = out_idx_reg;
        out_last_next = out_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_cmd == ptt_pkg::CMD_TICK)) begin
                    state_next = ST_WALK;
                    cnt_next   = '0;
                end
            end
            ST_WALK: begin
                if (!stall) begin
                    ev_vld_next = issue;
                    ev_idx_next = cnt_reg[IDX_W-1:0];
                    if (issue) begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (fire) begin
                        if (held_vld_reg) begin
                            out_vld_next  = 1'b1;
                            out_idx_next  = ptt_pkg::IDX_OUT_W'(held_idx_reg);
                            out_last_next = 1'b0;
                        end
                        held_vld_next = 1'b1;
                        held_idx_next = ev_idx_reg;
                    end
                    if ((cnt_reg == CNT_W'(NUM_ENTRIES)) && !ev_vld_reg) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!held_vld_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_idx_next  = ptt_pkg::IDX_OUT_W'(held_idx_reg);
                    out_last_next = 1'b1;
                    held_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            ev_vld_reg   <= 1'b0;
            held_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ev_vld_reg   <= ev_vld_next;
            held_vld_reg <= held_vld_next;
            out_vld_reg  <= out_vld_next;
        end
        ev_idx_reg   <= ev_idx_next;
        held_idx_reg <= held_idx_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid       = out_vld_reg;
    assign m_fired_index = out_idx_reg;
    assign m_last_fire   = out_last_reg;

    // ---------------- assertions ----------------
    // No fire may be left behind once a tick is finished.
    a_idle_no_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !held_vld_reg)
        else $error("held fire left over in idle");

    // The evaluate stage is only live during a walk.
    a_ev_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_vld_reg |-> (state_reg == ST_WALK))
        else $error("evaluate stage live outside walk");

    // Write-back never hits the entry being read in the same cycle.
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (wr_addr != rd_addr))
        else $error("entry memory read/write collision");

    // A stall holds the walk position.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> ($stable(cnt_reg) && ev_vld_reg))
        else $error("walk advanced during stall");

endmodule

`default_nettype wire
